// ----- rtl/smg_pkg.sv -----
`default_nettype none

package smg_pkg;

	localparam int SEG_W       = 7;
	localparam int MAX_SEG_DEF = 64;
	localparam int DIV_W       = 24;
	localparam int REM_W       = 7;
	localparam int ACC_W       = REM_W + DIV_W;
	localparam int NLANE       = 4;
	localparam int NCELL       = DIV_W;
	localparam int ADDR_W      = 5;

	// Lanes of the divider chain.
	localparam int LANE_PHI   = 0;
	localparam int LANE_THETA = 1;
	localparam int LANE_U     = 2;
	localparam int LANE_V     = 3;

	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_INDEX  = 1'b1;

	localparam logic [11:0] RADIUS_RST   = 12'd1;
	localparam logic [6:0]  WSEG_RST     = 7'd8;
	localparam logic [6:0]  HSEG_RST     = 7'd6;
	localparam logic [15:0] PHI_ST_RST   = 16'd0;
	localparam logic [16:0] PHI_LEN_RST  = 17'd65536;
	localparam logic [15:0] TH_ST_RST    = 16'd0;
	localparam logic [15:0] TH_LEN_RST   = 16'd32768;

	localparam logic signed [31:0] C_A1 = 32'sd421657428;
	localparam logic signed [31:0] C_A3 = -32'sd173399667;
	localparam logic signed [31:0] C_A5 = 32'sd21392326;
	localparam logic signed [31:0] C_A7 = -32'sd1256748;
	localparam logic signed [31:0] C_A9 = 32'sd43068;

	typedef enum logic [2:0] {
		REG_RADIUS      = 3'd0,
		REG_WSEG        = 3'd1,
		REG_HSEG        = 3'd2,
		REG_PHI_START   = 3'd3,
		REG_PHI_LEN     = 3'd4,
		REG_THETA_START = 3'd5,
		REG_THETA_LEN   = 3'd6
	} reg_sel_t;

	typedef struct packed {
		logic                        vld;
		logic [SEG_W-1:0]            col;
		logic [SEG_W-1:0]            row;
		logic [NLANE-1:0][ACC_W-1:0] acc;
	} cell_t;

	typedef struct packed {
		logic        neg;
		logic [14:0] t;
	} trig_arg_t;

	typedef struct packed {
		logic             vld;
		logic [SEG_W-1:0] col;
		logic [SEG_W-1:0] row;
		logic [16:0]      u;
		logic [16:0]      v;
	} side_t;

	typedef struct packed {
		logic               vld;
		logic signed [24:0] pos_x;
		logic signed [24:0] pos_y;
		logic signed [24:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic [16:0]        u;
		logic [16:0]        v;
		logic [12:0]        idx_a;
		logic [12:0]        idx_b;
		logic [12:0]        idx_c;
		logic [12:0]        idx_d;
		logic               first;
		logic               second;
	} vert_t;

	// Shift right with rounding half away from zero.
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int sh);
		logic [63:0] mag;
		logic [63:0] half;
		logic [63:0] res;
		half = 64'd1 << (sh - 1);
		if (v[63]) begin
			mag = 64'(-v);
			res = (mag + half) >> sh;
			return -$signed(res);
		end else begin
			mag = 64'(v);
			res = (mag + half) >> sh;
			return $signed(res);
		end
	endfunction

	// Folds a binary angle onto the quarter wave argument and the sign.
	function automatic trig_arg_t quarter_arg(input logic [15:0] a);
		trig_arg_t ta;
		ta.neg = a[15];
		if (a[14]) begin
			ta.t = 15'd16384 - {1'b0, a[13:0]};
		end else begin
			ta.t = {1'b0, a[13:0]};
		end
		return ta;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/smg_div_cell.sv -----
`default_nettype none

module smg_div_cell import smg_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic [SEG_W-1:0] ws,
	input  wire logic [SEG_W-1:0] hs,
	input  wire cell_t            cell_in,
	output cell_t                 cell_s1
);

	cell_t nxt;

	// One restoring step per lane: one quotient bit enters at the bottom.
	always_comb begin
		logic [REM_W:0] hi;
		logic [REM_W:0] dv;
		nxt = cell_in;
		for (int l = 0; l < NLANE; l++) begin
			dv = (l == LANE_PHI || l == LANE_U) ? {1'b0, ws} : {1'b0, hs};
			hi = cell_in.acc[l][ACC_W-1:DIV_W-1];
			if (hi >= dv) begin
				hi = hi - dv;
				nxt.acc[l] = {hi[REM_W-1:0], cell_in.acc[l][DIV_W-2:0], 1'b1};
			end else begin
				nxt.acc[l] = {hi[REM_W-1:0], cell_in.acc[l][DIV_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_s1 <= '0;
		end else if (adv) begin
			cell_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/smg_sin_pipe.sv -----
`default_nettype none

module smg_sin_pipe import smg_pkg::*; (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire trig_arg_t    arg,
	output logic signed [15:0] s_s6
);

	logic [14:0] t_s1, t_s2, t_s3, t_s4, t_s5;
	logic [28:0] t2_s1, t2_s2, t2_s3, t2_s4;
	logic        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic signed [31:0] p_s2, p_s3, p_s4, p_s5;
	logic signed [61:0] prod2, prod3, prod4, prod5;
	logic signed [47:0] prod6;
	logic signed [63:0] fin;
	logic signed [15:0] mag;

	assign prod2 = C_A9 * $signed({1'b0, t2_s1});
	assign prod3 = p_s2 * $signed({1'b0, t2_s2});
	assign prod4 = p_s3 * $signed({1'b0, t2_s3});
	assign prod5 = p_s4 * $signed({1'b0, t2_s4});
	assign prod6 = p_s5 * $signed({1'b0, t_s5});
	assign fin   = rnd_shift(64'(prod6), 28);

	always_comb begin
		if (fin < 0) begin
			mag = 16'sd0;
		end else if (fin > 64'sd16384) begin
			mag = 16'sd16384;
		end else begin
			mag = 16'(fin);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= arg.t;
			t2_s1  <= 29'(arg.t) * 29'(arg.t);
			neg_s1 <= arg.neg;
			t_s2   <= t_s1;
			t2_s2  <= t2_s1;
			neg_s2 <= neg_s1;
			p_s2   <= C_A7 + 32'(rnd_shift(64'(prod2), 28));
			t_s3   <= t_s2;
			t2_s3  <= t2_s2;
			neg_s3 <= neg_s2;
			p_s3   <= C_A5 + 32'(rnd_shift(64'(prod3), 28));
			t_s4   <= t_s3;
			t2_s4  <= t2_s3;
			neg_s4 <= neg_s3;
			p_s4   <= C_A3 + 32'(rnd_shift(64'(prod4), 28));
			t_s5   <= t_s4;
			neg_s5 <= neg_s4;
			p_s5   <= C_A1 + 32'(rnd_shift(64'(prod5), 28));
			s_s6   <= neg_s5 ? -mag : mag;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sphere_mesh_generator.sv -----
`default_nettype none

// Channel  | Direction | Payload
// s_*      | in        | tdata[6:0] col, tdata[13:7] row
// m_*      | out       | tdata vertex fields and index, tuser kind, tlast end of point
// APB      | in/out    | seven configuration registers at byte address 4*i
//
// A grid point travels through an input register, a row of 24 divider cells
// (one quotient bit each), an angle stage, a six-stage sine pipeline, a normal
// stage and a position stage into the output register, where its vertex result
// is offered.
// The output register then sends 1, 4 or 7 results, one a cycle while m_tready
// holds, and takes no new point before its final result; that sequencer sets the sustained rate.
// Reset clears every valid flag and loads the registers with their defaults.
// A stall on the result side freezes the whole row of stages together.
module sphere_mesh_generator import smg_pkg::*; #(
	parameter int MAX_SEGMENTS = MAX_SEG_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [15:0]       s_tdata,   // col[6:0], row[13:7], zero pad
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [175:0]           m_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y,
	                                          // norm_z, tex_u, tex_v, vert_index, pad
	output logic [0:0]             m_tuser,   // kind
	output logic                   m_tlast,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	// Configuration registers.
	logic [11:0] radius_q;
	logic [6:0]  wseg_q, hseg_q;
	logic [15:0] phi_st_q, th_st_q, th_len_q;
	logic [16:0] phi_len_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= RADIUS_RST;
			wseg_q    <= WSEG_RST;
			hseg_q    <= HSEG_RST;
			phi_st_q  <= PHI_ST_RST;
			phi_len_q <= PHI_LEN_RST;
			th_st_q   <= TH_ST_RST;
			th_len_q  <= TH_LEN_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel_t'(paddr[4:2]))
				REG_RADIUS:      radius_q  <= pwdata[11:0];
				REG_WSEG:        wseg_q    <= pwdata[6:0];
				REG_HSEG:        hseg_q    <= pwdata[6:0];
				REG_PHI_START:   phi_st_q  <= pwdata[15:0];
				REG_PHI_LEN:     phi_len_q <= pwdata[16:0];
				REG_THETA_START: th_st_q   <= pwdata[15:0];
				REG_THETA_LEN:   th_len_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel_t'(paddr[4:2]))
			REG_RADIUS:      prdata = {20'd0, radius_q};
			REG_WSEG:        prdata = {25'd0, wseg_q};
			REG_HSEG:        prdata = {25'd0, hseg_q};
			REG_PHI_START:   prdata = {16'd0, phi_st_q};
			REG_PHI_LEN:     prdata = {15'd0, phi_len_q};
			REG_THETA_START: prdata = {16'd0, th_st_q};
			REG_THETA_LEN:   prdata = {16'd0, th_len_q};
			default:         prdata = 32'd0;
		endcase
	end

	// Segment counts: zero counts as one, large counts saturate.
	logic [SEG_W-1:0] ws, hs;

	always_comb begin
		if (wseg_q == '0) begin
			ws = SEG_W'(1);
		end else if (int'(wseg_q) > MAX_SEGMENTS) begin
			ws = SEG_W'(MAX_SEGMENTS);
		end else begin
			ws = wseg_q;
		end
		if (hseg_q == '0) begin
			hs = SEG_W'(1);
		end else if (int'(hseg_q) > MAX_SEGMENTS) begin
			hs = SEG_W'(MAX_SEGMENTS);
		end else begin
			hs = hseg_q;
		end
	end

	// The whole row of stages moves when the output register frees up.
	logic  adv;
	logic  out_vld;
	logic  out_last;
	assign adv      = !out_vld || (m_tready && out_last);
	assign s_tready = adv;

	// Input register with the column and row saturated.
	logic             in_vld_s1;
	logic [SEG_W-1:0] col_s1, row_s1;
	logic [SEG_W-1:0] col_in, row_in;

	assign col_in = (s_tdata[6:0] > ws) ? ws : s_tdata[6:0];
	assign row_in = (s_tdata[13:7] > hs) ? hs : s_tdata[13:7];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
			col_s1    <= '0;
			row_s1    <= '0;
		end else if (adv) begin
			in_vld_s1 <= s_tvalid;
			col_s1    <= col_in;
			row_s1    <= row_in;
		end
	end

	// Dividends for the four quotients: both angle steps, u and v.
	logic [DIV_W-1:0] phi_num, th_num;
	cell_t            chain [0:NCELL];

	assign phi_num = DIV_W'(col_s1) * DIV_W'(phi_len_q);
	assign th_num  = DIV_W'(row_s1) * DIV_W'(th_len_q);

	always_comb begin
		chain[0].vld             = in_vld_s1;
		chain[0].col             = col_s1;
		chain[0].row             = row_s1;
		chain[0].acc[LANE_PHI]   = {{REM_W{1'b0}}, phi_num};
		chain[0].acc[LANE_THETA] = {{REM_W{1'b0}}, th_num};
		chain[0].acc[LANE_U]     = {{REM_W{1'b0}}, 1'b0, col_s1, 16'd0};
		chain[0].acc[LANE_V]     = {{REM_W{1'b0}}, 1'b0, row_s1, 16'd0};
	end

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		smg_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.ws      (ws),
			.hs      (hs),
			.cell_in (chain[g]),
			.cell_s1 (chain[g+1])
		);
	end

	// Angle stage: sum with the start angles and fold onto a quarter wave.
	cell_t       dv;
	logic [15:0] phi_a, th_a;
	side_t       side_s2;
	trig_arg_t   sp_s2, cp_s2, st_s2, ct_s2;

	assign dv    = chain[NCELL];
	assign phi_a = phi_st_q + dv.acc[LANE_PHI][15:0];
	assign th_a  = th_st_q + dv.acc[LANE_THETA][15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else if (adv) begin
			side_s2.vld <= dv.vld;
			side_s2.col <= dv.col;
			side_s2.row <= dv.row;
			side_s2.u   <= dv.acc[LANE_U][16:0];
			side_s2.v   <= 17'd65536 - dv.acc[LANE_V][16:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sp_s2 <= quarter_arg(phi_a);
			cp_s2 <= quarter_arg(phi_a + 16'd16384);
			st_s2 <= quarter_arg(th_a);
			ct_s2 <= quarter_arg(th_a + 16'd16384);
		end
	end

	// Four sine evaluations in step, side data delayed alongside.
	logic signed [15:0] sp_v, cp_v, st_v, ct_v;
	side_t              side_dly_q [0:5];

	smg_sin_pipe u_sin_sp (.clk(clk), .en(adv), .arg(sp_s2), .s_s6(sp_v));
	smg_sin_pipe u_sin_cp (.clk(clk), .en(adv), .arg(cp_s2), .s_s6(cp_v));
	smg_sin_pipe u_sin_st (.clk(clk), .en(adv), .arg(st_s2), .s_s6(st_v));
	smg_sin_pipe u_sin_ct (.clk(clk), .en(adv), .arg(ct_s2), .s_s6(ct_v));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				side_dly_q[i] <= '0;
			end
		end else if (adv) begin
			side_dly_q[0] <= side_s2;
			for (int i = 1; i < 6; i++) begin
				side_dly_q[i] <= side_dly_q[i-1];
			end
		end
	end

	// Normal stage.
	logic signed [31:0] prod_x, prod_z;
	logic signed [15:0] nx_s3, ny_s3, nz_s3;
	side_t              side_s3;

	assign prod_x = cp_v * st_v;
	assign prod_z = sp_v * st_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else if (adv) begin
			side_s3 <= side_dly_q[5];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s3 <= -16'(rnd_shift(64'(prod_x), 14));
			ny_s3 <= ct_v;
			nz_s3 <= 16'(rnd_shift(64'(prod_z), 14));
		end
	end

	// Position and triangle index stage.
	logic signed [28:0] rx, ry, rz;
	logic [7:0]         stride;
	logic [12:0]        idx_b, idx_c;
	logic [16:0]        th_end;
	logic               in_cell;
	vert_t              vert_d, vert_s4;

	assign rx      = $signed({1'b0, radius_q}) * nx_s3;
	assign ry      = $signed({1'b0, radius_q}) * ny_s3;
	assign rz      = $signed({1'b0, radius_q}) * nz_s3;
	assign stride  = {1'b0, ws} + 8'd1;
	assign idx_b   = 13'(side_s3.row) * 13'(stride) + 13'(side_s3.col);
	assign idx_c   = idx_b + 13'(stride);
	assign th_end  = {1'b0, th_st_q} + {1'b0, th_len_q};
	assign in_cell = (side_s3.col < ws) && (side_s3.row < hs);

	always_comb begin
		vert_d.vld    = side_s3.vld;
		vert_d.pos_x  = 25'(rnd_shift(64'(rx), 2));
		vert_d.pos_y  = 25'(rnd_shift(64'(ry), 2));
		vert_d.pos_z  = 25'(rnd_shift(64'(rz), 2));
		vert_d.norm_x = nx_s3;
		vert_d.norm_y = ny_s3;
		vert_d.norm_z = nz_s3;
		vert_d.u      = side_s3.u;
		vert_d.v      = side_s3.v;
		vert_d.idx_a  = idx_b + 13'd1;
		vert_d.idx_b  = idx_b;
		vert_d.idx_c  = idx_c;
		vert_d.idx_d  = idx_c + 13'd1;
		// On the top row the first triangle is dropped when the polar start is
		// zero, on the bottom row the second when the sweep reaches the opposite pole.
		vert_d.first  = in_cell && ((side_s3.row != '0) || (th_st_q != '0));
		vert_d.second = in_cell && ((side_s3.row != hs - SEG_W'(1)) ||
		                            (th_end < 17'd32768));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_s4 <= '0;
		end else if (adv) begin
			vert_s4 <= vert_d;
		end
	end

	// Output register and result sequencer. Phase zero sends the vertex; the
	// following phases send the corners of the first and second triangle.
	vert_t      out_q;
	logic [2:0] phase_q;
	logic [12:0] vidx;
	logic [2:0]  final_phase;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q   <= '0;
			phase_q <= '0;
		end else if (adv) begin
			out_q   <= vert_s4;
			phase_q <= '0;
		end else if (m_tvalid && m_tready) begin
			phase_q <= phase_q + 3'd1;
		end
	end

	assign out_vld  = out_q.vld;
	assign m_tvalid = out_vld;

	always_comb begin
		if (out_q.first && out_q.second) begin
			final_phase = 3'd6;
		end else if (out_q.first || out_q.second) begin
			final_phase = 3'd3;
		end else begin
			final_phase = 3'd0;
		end
		case (phase_q)
			3'd0:    vidx = out_q.idx_b;
			3'd1:    vidx = out_q.first ? out_q.idx_a : out_q.idx_b;
			3'd2:    vidx = out_q.first ? out_q.idx_b : out_q.idx_c;
			3'd3:    vidx = out_q.idx_d;
			3'd4:    vidx = out_q.idx_b;
			3'd5:    vidx = out_q.idx_c;
			3'd6:    vidx = out_q.idx_d;
			default: vidx = out_q.idx_b;
		endcase
	end

	assign out_last = (phase_q == final_phase);
	assign m_tlast  = out_last;

	always_comb begin
		m_tdata = '0;
		m_tdata[169:157] = vidx;
		if (phase_q == 3'd0) begin
			m_tuser[0]       = KIND_VERTEX;
			m_tdata[24:0]    = out_q.pos_x;
			m_tdata[49:25]   = out_q.pos_y;
			m_tdata[74:50]   = out_q.pos_z;
			m_tdata[90:75]   = out_q.norm_x;
			m_tdata[106:91]  = out_q.norm_y;
			m_tdata[122:107] = out_q.norm_z;
			m_tdata[139:123] = out_q.u;
			m_tdata[156:140] = out_q.v;
		end else begin
			m_tuser[0] = KIND_INDEX;
		end
	end

`ifndef SYNTHESIS
	// After the final result of a point, the next result opens with a vertex.
	a_vertex_first: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || (m_tuser[0] == KIND_VERTEX)))
		else $error("result after a final transfer is not a vertex");

	// A transfer that is not final keeps the point and moves to an index.
	a_index_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && (m_tuser[0] == KIND_INDEX)))
		else $error("point dropped before its final result");

	// The sequencer never runs past the seventh result.
	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != 3'd0) |-> (out_vld && (phase_q <= final_phase)))
		else $error("result sequencer out of range");
`endif

endmodule

`default_nettype wire
